/* src/glmf_pkg.sv */
// Package for the grid local minimum finder: field widths, register codes,
// the row store entry, the result word and the risk adder. No dependencies.
package glmf_pkg;

    localparam int HEIGHT_W    = 4;
    localparam int COORD_W     = 7;
    localparam int RISK_W      = 18;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;

    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 8'd128;
    localparam logic [RISK_W-1:0]     RISK_MAX       = {RISK_W{1'b1}};

    // One row store entry: the height and whether the cell above is higher or absent.
    typedef struct packed {
        logic                up_ok;
        logic [HEIGHT_W-1:0] height;
    } t_entry;

    typedef struct packed {
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  column;
        logic                low;
        logic [HEIGHT_W-1:0] height;
        logic [RISK_W-1:0]   risk;
        logic                last;
    } t_result;

    // The item held in the compute stage, with its position flags.
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  column;
        logic                row_ge1;
        logic                col_ge1;
        logic                col_ge2;
        logic                last_col;
        logic                last_row;
    } t_ctx;

    // Neighbourhood seen by the item: previous row around its column and
    // the two cells before it in its own row.
    typedef struct packed {
        logic [HEIGHT_W-1:0] prv_left;
        t_entry              prv_mid;
        logic [HEIGHT_W-1:0] prv_right;
        logic [HEIGHT_W-1:0] recent0;
        logic [HEIGHT_W-1:0] recent1;
    } t_nbr;

    typedef struct packed {
        t_result           res_above;
        t_result           res_left;
        t_result           res_final;
        logic              v_above;
        logic              v_left;
        logic              v_final;
        logic [1:0]        count;
        logic [RISK_W-1:0] risk_next;
    } t_verdict;

    // Adds height plus one to the risk sum for a low point, saturating.
    function automatic logic [RISK_W-1:0] risk_add(input logic [RISK_W-1:0] risk,
                                                   input logic low,
                                                   input logic [HEIGHT_W-1:0] height);
        logic [RISK_W:0] sum;
        sum = {1'b0, risk} + (RISK_W+1)'(height) + (RISK_W+1)'(1);
        if (!low) begin
            return risk;
        end else if (sum > {1'b0, RISK_MAX}) begin
            return RISK_MAX;
        end else begin
            return sum[RISK_W-1:0];
        end
    endfunction

endpackage

/* src/glmf_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module glmf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/glmf_decide.sv */
// Decides the up to three cells settled by one incoming height and extends the risk sum.
// Depends on glmf_pkg.
module glmf_decide (
    input  glmf_pkg::t_ctx                   i_ctx,
    input  glmf_pkg::t_nbr                   i_nbr,
    input  logic [glmf_pkg::RISK_W-1:0]      i_risk,
    output glmf_pkg::t_verdict               o_verdict
);

    logic [glmf_pkg::HEIGHT_W-1:0] v_above;
    logic                          low_above;
    logic                          low_left;
    logic                          low_final;
    logic [glmf_pkg::RISK_W-1:0]   risk_a;
    logic [glmf_pkg::RISK_W-1:0]   risk_l;
    logic [glmf_pkg::RISK_W-1:0]   risk_f;

    always_comb begin
        v_above   = i_nbr.prv_mid.height;
        // Cell above: its lower neighbour has just arrived.
        low_above = (i_ctx.height > v_above) && i_nbr.prv_mid.up_ok
                    && (!i_ctx.col_ge1 || (i_nbr.prv_left > v_above))
                    && (i_ctx.last_col || (i_nbr.prv_right > v_above));
        // Left cell on the last row: its right neighbour has just arrived.
        low_left  = (i_ctx.height > i_nbr.recent0)
                    && (!i_ctx.col_ge2 || (i_nbr.recent1 > i_nbr.recent0))
                    && (!i_ctx.row_ge1 || (i_nbr.prv_left > i_nbr.recent0));
        // Final cell of the frame: only left and above can exist.
        low_final = !(i_ctx.col_ge1 && (i_nbr.recent0 <= i_ctx.height))
                    && !(i_ctx.row_ge1 && (i_nbr.prv_mid.height <= i_ctx.height));

        o_verdict.v_above = i_ctx.row_ge1;
        o_verdict.v_left  = i_ctx.last_row && i_ctx.col_ge1;
        o_verdict.v_final = i_ctx.last_row && i_ctx.last_col;

        risk_a = o_verdict.v_above ? glmf_pkg::risk_add(i_risk, low_above, v_above) : i_risk;
        risk_l = o_verdict.v_left  ? glmf_pkg::risk_add(risk_a, low_left, i_nbr.recent0)
                                   : risk_a;
        risk_f = o_verdict.v_final ? glmf_pkg::risk_add(risk_l, low_final, i_ctx.height)
                                   : risk_l;

        o_verdict.res_above.row    = i_ctx.row - glmf_pkg::COORD_W'(1);
        o_verdict.res_above.column = i_ctx.column;
        o_verdict.res_above.low    = low_above;
        o_verdict.res_above.height = v_above;
        o_verdict.res_above.risk   = risk_a;
        o_verdict.res_above.last   = 1'b0;

        o_verdict.res_left.row     = i_ctx.row;
        o_verdict.res_left.column  = i_ctx.column - glmf_pkg::COORD_W'(1);
        o_verdict.res_left.low     = low_left;
        o_verdict.res_left.height  = i_nbr.recent0;
        o_verdict.res_left.risk    = risk_l;
        o_verdict.res_left.last    = 1'b0;

        o_verdict.res_final.row    = i_ctx.row;
        o_verdict.res_final.column = i_ctx.column;
        o_verdict.res_final.low    = low_final;
        o_verdict.res_final.height = i_ctx.height;
        o_verdict.res_final.risk   = risk_f;
        o_verdict.res_final.last   = 1'b1;

        o_verdict.count = 2'(o_verdict.v_above) + 2'(o_verdict.v_left)
                          + 2'(o_verdict.v_final);
        // The frame ends with its final cell, and the sum starts again.
        o_verdict.risk_next = o_verdict.v_final ? '0 : risk_f;
    end

endmodule

/* src/grid_local_minimum_finder_unit.sv */
// Top level of the grid local minimum finder: counters, compute stage, row store and result queue.
// Depends on glmf_pkg, glmf_ram and glmf_decide.
//
// Usage. Heights arrive in raster order on the input channel (i_valid, o_ready, i_height),
// one word per cell. Each cell's verdict leaves on the output channel (o_valid, i_ready and
// the result fields) as soon as its last neighbour is known: one row late, except on the last
// row, where a cell is settled when its right neighbour arrives and the final cell on the
// frame's last word, which carries o_frame_last. The frame size is set through the
// configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data); a write rewinds
// the frame and the risk sum, and must only be made while the block is idle.
// Timing. A word is taken into the compute stage at the edge of acceptance and its results
// enter a four-word result queue when the stage advances, which waits for room in the queue.
// One word per cycle is taken while one result per word is produced and the queue has room;
// on the last row each word but the first makes two results, and the frame's last word three,
// so there the rate is set by the single output port of the queue.
// Reset clears the counters, the queue and the compute stage; the frame size returns to
// 128 by 128. The row store needs no clearing, as a frame only reads what it wrote.
// When the receiver stalls, the queue fills, the compute stage holds its word, and o_ready
// falls until there is room again; no word is lost or repeated.
module grid_local_minimum_finder_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [glmf_pkg::HEIGHT_W-1:0]       i_height,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [glmf_pkg::COORD_W-1:0]        o_cell_row,
    output logic [glmf_pkg::COORD_W-1:0]        o_cell_column,
    output logic                                o_is_low_point,
    output logic [glmf_pkg::HEIGHT_W-1:0]       o_cell_height,
    output logic [glmf_pkg::RISK_W-1:0]         o_risk_total,
    output logic                                o_frame_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [glmf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [glmf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W     = $clog2(MAX_COLUMNS);
    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_CMP_W = (CNT_W + 1 > glmf_pkg::CFG_DATA_W) ? CNT_W + 1
                                                                  : glmf_pkg::CFG_DATA_W;
    localparam int ROW_CMP_W = (RW + 1 > glmf_pkg::CFG_DATA_W) ? RW + 1
                                                               : glmf_pkg::CFG_DATA_W;
    localparam int ENTRY_W   = $bits(glmf_pkg::t_entry);

    // Configuration registers.
    logic [glmf_pkg::CFG_DATA_W-1:0] r_cfg_columns;
    logic [glmf_pkg::CFG_DATA_W-1:0] r_cfg_rows;
    logic                            cfg_wr;

    // Position of the next word to be accepted.
    logic [CNT_W-1:0] r_col;
    logic [RW-1:0]    r_row;
    logic [CNT_W-1:0] last_col_idx;
    logic [RW-1:0]    last_row_idx;
    logic [COL_CMP_W-1:0] col_cfg_ext;
    logic [ROW_CMP_W-1:0] row_cfg_ext;
    logic             at_last_col;
    logic             at_last_row;
    logic             in_acc;
    glmf_pkg::t_ctx   n_ctx;

    // Compute stage.
    logic             r_s1_valid;
    glmf_pkg::t_ctx   r_s1_ctx;
    logic [CNT_W-1:0] r_s1_col;
    logic             s1_adv;
    glmf_pkg::t_nbr   nbr;
    glmf_pkg::t_verdict verdict;
    logic [glmf_pkg::RISK_W-1:0] r_risk;
    logic [glmf_pkg::HEIGHT_W-1:0] r_recent0;
    logic [glmf_pkg::HEIGHT_W-1:0] r_recent1;

    // Row store access, with a bypass for a read that meets a write at the same column.
    logic             wr_en;
    glmf_pkg::t_entry wr_data;
    logic [CNT_W-1:0] rd_addr;
    logic [CNT_W-1:0] r_rd_addr;
    logic [ENTRY_W-1:0] ram_q;
    logic             r_byp_v;
    glmf_pkg::t_entry r_byp_d;
    glmf_pkg::t_entry eff_rd;
    glmf_pkg::t_entry eff_next;
    logic             wr_hit;
    glmf_pkg::t_entry r_prv_mid;
    logic [glmf_pkg::HEIGHT_W-1:0] r_prv_left;

    // Result queue.
    glmf_pkg::t_result r_fifo [glmf_pkg::FIFO_DEPTH];
    logic [glmf_pkg::FIFO_PTR_W-1:0] r_head;
    logic [glmf_pkg::FIFO_PTR_W-1:0] r_tail;
    logic [glmf_pkg::FIFO_CNT_W-1:0] r_count;
    logic [glmf_pkg::FIFO_CNT_W-1:0] free_slots;
    logic [glmf_pkg::FIFO_CNT_W-1:0] push_n;
    logic                            pop;
    logic [glmf_pkg::FIFO_PTR_W-1:0] off_left;
    logic [glmf_pkg::FIFO_PTR_W-1:0] off_final;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Frame size: zero acts as one, anything beyond the maximum acts as the maximum.
    always_comb begin
        col_cfg_ext = COL_CMP_W'(r_cfg_columns);
        row_cfg_ext = ROW_CMP_W'(r_cfg_rows);
        if (col_cfg_ext == '0) begin
            last_col_idx = '0;
        end else if (col_cfg_ext > COL_CMP_W'(MAX_COLUMNS)) begin
            last_col_idx = CNT_W'(MAX_COLUMNS - 1);
        end else begin
            last_col_idx = CNT_W'(col_cfg_ext - COL_CMP_W'(1));
        end
        if (row_cfg_ext == '0) begin
            last_row_idx = '0;
        end else if (row_cfg_ext > ROW_CMP_W'(MAX_ROWS)) begin
            last_row_idx = RW'(MAX_ROWS - 1);
        end else begin
            last_row_idx = RW'(row_cfg_ext - ROW_CMP_W'(1));
        end
    end

    assign at_last_col = (r_col == last_col_idx);
    assign at_last_row = (r_row == last_row_idx);

    always_comb begin
        n_ctx.height   = i_height;
        n_ctx.row      = glmf_pkg::COORD_W'(r_row);
        n_ctx.column   = glmf_pkg::COORD_W'(r_col);
        n_ctx.row_ge1  = (r_row != '0);
        n_ctx.col_ge1  = (r_col != '0);
        n_ctx.col_ge2  = ((CNT_W+1)'(r_col) >= (CNT_W+1)'(2));
        n_ctx.last_col = at_last_col;
        n_ctx.last_row = at_last_row;
    end

    // The read runs one column ahead: at the row's end it fetches column zero for the next row.
    assign rd_addr = at_last_col ? '0 : r_col + CNT_W'(1);

    assign free_slots = glmf_pkg::FIFO_CNT_W'(glmf_pkg::FIFO_DEPTH) - r_count;
    assign s1_adv     = r_s1_valid && (free_slots >= glmf_pkg::FIFO_CNT_W'(verdict.count));
    assign o_ready    = !r_s1_valid || s1_adv;
    assign in_acc     = i_valid && o_ready;

    assign wr_en          = s1_adv;
    assign wr_data.height = r_s1_ctx.height;
    assign wr_data.up_ok  = !r_s1_ctx.row_ge1 || (r_prv_mid.height > r_s1_ctx.height);
    assign wr_hit         = wr_en && (r_s1_col == r_rd_addr);
    assign eff_rd         = r_byp_v ? r_byp_d : glmf_pkg::t_entry'(ram_q);
    assign eff_next       = wr_hit ? wr_data : eff_rd;

    glmf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLUMNS)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        nbr.prv_left  = r_prv_left;
        nbr.prv_mid   = r_prv_mid;
        nbr.prv_right = eff_rd.height;
        nbr.recent0   = r_recent0;
        nbr.recent1   = r_recent1;
    end

    glmf_decide u_decide (
        .i_ctx     (r_s1_ctx),
        .i_nbr     (nbr),
        .i_risk    (r_risk),
        .o_verdict (verdict)
    );

    // Configuration and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_columns <= glmf_pkg::CFG_SIZE_RESET;
            r_cfg_rows    <= glmf_pkg::CFG_SIZE_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_risk        <= '0;
        end else begin
            if (cfg_wr && (i_cfg_index == glmf_pkg::CFG_COLUMNS)) begin
                r_cfg_columns <= i_cfg_data;
            end
            if (cfg_wr && (i_cfg_index == glmf_pkg::CFG_ROWS)) begin
                r_cfg_rows <= i_cfg_data;
            end
            if (cfg_wr && ((i_cfg_index == glmf_pkg::CFG_COLUMNS)
                           || (i_cfg_index == glmf_pkg::CFG_ROWS))) begin
                r_col  <= '0;
                r_row  <= '0;
                r_risk <= '0;
            end else begin
                if (in_acc) begin
                    if (!at_last_col) begin
                        r_col <= r_col + CNT_W'(1);
                    end else begin
                        r_col <= '0;
                        r_row <= at_last_row ? '0 : r_row + RW'(1);
                    end
                end
                if (s1_adv) begin
                    r_risk <= verdict.risk_next;
                end
            end
        end
    end

    // Compute stage control and the read bypass flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp_v    <= 1'b0;
            r_rd_addr  <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (in_acc) begin
                r_rd_addr <= rd_addr;
                r_byp_v   <= wr_en && (r_s1_col == rd_addr);
            end else if (wr_hit) begin
                r_byp_v <= 1'b1;
            end
        end
    end

    // Payload of the compute stage and the neighbourhood window.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctx   <= n_ctx;
            r_s1_col   <= r_col;
            r_byp_d    <= wr_data;
            r_prv_left <= r_prv_mid.height;
            r_prv_mid  <= eff_next;
        end else if (wr_hit) begin
            r_byp_d <= wr_data;
        end
        if (s1_adv) begin
            r_recent1 <= r_recent0;
            r_recent0 <= r_s1_ctx.height;
        end
    end

    // Result queue: up to three words pushed at once, one taken per cycle while the receiver is ready.
    assign pop       = o_valid && i_ready;
    assign push_n    = s1_adv ? glmf_pkg::FIFO_CNT_W'(verdict.count) : '0;
    assign off_left  = glmf_pkg::FIFO_PTR_W'(verdict.v_above);
    assign off_final = glmf_pkg::FIFO_PTR_W'(verdict.v_above)
                       + glmf_pkg::FIFO_PTR_W'(verdict.v_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + glmf_pkg::FIFO_PTR_W'(push_n);
            r_count <= r_count + push_n - glmf_pkg::FIFO_CNT_W'(pop);
            if (pop) begin
                r_head <= r_head + glmf_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (verdict.v_above) begin
                r_fifo[r_tail] <= verdict.res_above;
            end
            if (verdict.v_left) begin
                r_fifo[r_tail + off_left] <= verdict.res_left;
            end
            if (verdict.v_final) begin
                r_fifo[r_tail + off_final] <= verdict.res_final;
            end
        end
    end

    assign o_valid        = (r_count != '0);
    assign o_cell_row     = r_fifo[r_head].row;
    assign o_cell_column  = r_fifo[r_head].column;
    assign o_is_low_point = r_fifo[r_head].low;
    assign o_cell_height  = r_fifo[r_head].height;
    assign o_risk_total   = r_fifo[r_head].risk;
    assign o_frame_last   = r_fifo[r_head].last;

    // The queue never holds more words than it has slots.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= glmf_pkg::FIFO_CNT_W'(glmf_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // A word held back by a full queue stays in the compute stage unchanged.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_ctx)))
        else $error("compute stage lost a held word");

    // The risk sum starts again after the frame's final cell.
    a_risk_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && verdict.v_final) |=> (r_risk == '0))
        else $error("risk sum not rewound at frame end");

endmodule
